// ----- hdl/gb5_pkg.sv -----
package gb5_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int KSIZE       = 5;
    localparam int LINES       = KSIZE - 1;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int COORD_W     = 10;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LINE_W      = LINES * PIX_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);

    // weighted row sum and window sum widths (max 27285 and 69615)
    localparam int RS_W        = 15;
    localparam int SUM_W       = 17;

    // divide by 273: floor(sum * 245821 / 2^26), exact for sum < 2^17
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(245821);

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [5:0] KERN [KSIZE][KSIZE] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] gb5_win_t;
    typedef logic [KSIZE-1:0][PIX_W-1:0]            gb5_col_t;

    typedef struct packed {
        logic               emit;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } gb5_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0]   filtered;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } gb5_res_t;

endpackage

// ----- hdl/gb5_ram.sv -----
module gb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/gb5_kernel.sv -----
module gb5_kernel (
    input  logic              clk,
    input  logic              rst_n,
    input  gb5_pkg::gb5_win_t win,
    input  gb5_pkg::gb5_tag_t tag_in,
    output logic              push,
    output gb5_pkg::gb5_res_t res,
    output logic [1:0]        inflight
);
    import gb5_pkg::*;

    gb5_tag_t              t2_reg;
    gb5_tag_t              t3_reg;
    gb5_tag_t              t4_reg;
    logic [RS_W-1:0]       rs_reg [KSIZE];
    logic [RS_W-1:0]       rs_next [KSIZE];
    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      total_next;
    logic [PROD_W-1:0]     prod;
    logic [PIX_W-1:0]      filt_reg;

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            rs_next[r] = '0;
            for (int c = 0; c < KSIZE; c++)
            begin
                rs_next[r] = rs_next[r] + RS_W'(KERN[r][c]) * RS_W'(win[r][c]);
            end
        end
        total_next = '0;
        for (int r = 0; r < KSIZE; r++)
        begin
            total_next = total_next + SUM_W'(rs_reg[r]);
        end
        prod = PROD_W'(total_reg) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t2_reg <= tag_in;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            rs_reg[r] <= rs_next[r];
        end
        total_reg <= total_next;
        filt_reg  <= prod[RECIP_SHIFT +: PIX_W];
    end

    assign push         = t4_reg.emit;
    assign res.filtered = filt_reg;
    assign res.cx       = t4_reg.cx;
    assign res.cy       = t4_reg.cy;
    assign inflight     = 2'(t2_reg.emit) + 2'(t3_reg.emit) + 2'(t4_reg.emit);

endmodule

// ----- hdl/gaussian_blur_5x5.sv -----
// 5x5 Gaussian blur (kernel sum 273) over 8-bit grayscale pixels in raster
// order. One pixel is taken per clock while pix_stall is low; a filtered
// pixel comes out for each input whose window lies fully inside the frame,
// tagged with the window centre, after passing the s1 and s2 registers, the
// kernel registers and the output buffer. The four previous rows sit in one
// 1024 x 32 line memory that is read and written back once per pixel, so the
// memory port sets the rate of one pixel per clock. Results queue in an
// 8-beat output buffer; outside the memory clear, pix_stall rises only when
// that buffer could overflow. After reset the line memory is cleared, with
// pix_stall high, before the first pixel. image_width is clamped to 5..1024.
module gaussian_blur_5x5 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pix_valid,
    output logic                         pix_stall,
    input  logic [gb5_pkg::PIX_W-1:0]    pixel,
    input  logic                         frame_start,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [gb5_pkg::PIX_W-1:0]    filtered,
    output logic [gb5_pkg::COORD_W-1:0]  center_x,
    output logic [gb5_pkg::COORD_W-1:0]  center_y,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gb5_pkg::CFG_W-1:0]    cfg_data
);
    import gb5_pkg::*;

    logic [CFG_W-1:0]   width_reg;
    logic [ADDR_W-1:0]  col_reg;
    logic [ADDR_W-1:0]  col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    logic               accept;
    logic [ADDR_W-1:0]  col_base;
    logic [ROW_W-1:0]   row_base;
    logic [CFG_W-1:0]   eff_w;
    logic               wrap;
    logic               emit;

    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [COORD_W-1:0] s1_cx_reg;
    logic [COORD_W-1:0] s1_cy_reg;
    logic               s2_emit_reg;
    logic [COORD_W-1:0] s2_cx_reg;
    logic [COORD_W-1:0] s2_cy_reg;
    logic               fwd_reg;
    logic               fwd_next;
    logic [LINE_W-1:0]  hold_reg;

    logic [LINE_W-1:0]  rd_word;
    logic [LINE_W-1:0]  wr_word;
    gb5_col_t           col_pix;
    gb5_win_t           win_reg;
    gb5_win_t           win_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [LINE_W-1:0]  ram_wdata;
    logic [LINE_W-1:0]  ram_rdata;

    gb5_tag_t           k_tag;
    logic               push;
    gb5_res_t           k_res;
    logic [1:0]         inflight;

    gb5_res_t           fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg;
    logic [FIFO_AW:0]   pending;
    logic               pop;

    // position and emit decision for the incoming pixel
    always_comb
    begin
        accept   = pix_valid && !pix_stall;
        col_base = frame_start ? '0 : col_reg;
        row_base = frame_start ? '0 : row_reg;
        if (width_reg < CFG_W'(KSIZE))
        begin
            eff_w = CFG_W'(KSIZE);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        wrap = (CFG_W'(col_base) + CFG_W'(1)) >= eff_w;
        emit = (col_base >= ADDR_W'(LINES)) && (row_base >= ROW_W'(LINES));
        if (wrap)
        begin
            col_next = '0;
            row_next = (row_base == ROW_W'(MAX_HEIGHT - 1)) ? row_base : row_base + 1'b1;
        end
        else
        begin
            col_next = col_base + 1'b1;
            row_next = row_base;
        end
        fwd_next = s1_valid_reg && (s1_addr_reg == col_base);
    end

    // line column update and window shift
    always_comb
    begin
        rd_word = fwd_reg ? hold_reg : ram_rdata;
        for (int r = 0; r < LINES; r++)
        begin
            col_pix[r] = rd_word[(LINES - 1 - r) * PIX_W +: PIX_W];
        end
        col_pix[KSIZE-1] = s1_pix_reg;
        wr_word = {rd_word[LINE_W-PIX_W-1:0], s1_pix_reg};
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
            win_next[r][KSIZE-1] = col_pix[r];
        end
        ram_we    = clr_active_reg || s1_valid_reg;
        ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
        ram_wdata = clr_active_reg ? '0 : wr_word;
    end

    gb5_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_base),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s1_emit_reg    <= 1'b0;
            s2_emit_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
            s2_emit_reg  <= s1_emit_reg;
            fwd_reg      <= accept && fwd_next;
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= col_base;
        s1_pix_reg  <= pixel;
        s1_cx_reg   <= COORD_W'(col_base - ADDR_W'(2));
        s1_cy_reg   <= COORD_W'(row_base - ROW_W'(2));
        s2_cx_reg   <= s1_cx_reg;
        s2_cy_reg   <= s1_cy_reg;
        if (s1_valid_reg)
        begin
            hold_reg <= wr_word;
        end
    end

    // tag is registered alongside the window update and enters the kernel with it
    assign k_tag.emit = s2_emit_reg;
    assign k_tag.cx   = s2_cx_reg;
    assign k_tag.cy   = s2_cy_reg;

    gb5_kernel u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win_reg),
        .tag_in   (k_tag),
        .push     (push),
        .res      (k_res),
        .inflight (inflight)
    );

    // output buffer with credit on every result still in the pipe
    always_comb
    begin
        pop     = res_valid && !res_stall;
        pending = fifo_cnt_reg + (FIFO_AW+1)'(s1_emit_reg) + (FIFO_AW+1)'(s2_emit_reg)
                  + (FIFO_AW+1)'(inflight);
    end

    assign pix_stall = clr_active_reg || (pending >= (FIFO_AW+1)'(FIFO_DEPTH));
    assign cfg_ready = 1'b1;
    assign res_valid = (fifo_cnt_reg != '0);
    assign filtered  = fifo_mem_reg[rd_ptr_reg].filtered;
    assign center_x  = fifo_mem_reg[rd_ptr_reg].cx;
    assign center_y  = fifo_mem_reg[rd_ptr_reg].cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= k_res;
        end
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("output buffer count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result pushed into full output buffer");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !push)
        else $error("pixel in flight during line memory clear");

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg && $past(s1_valid_reg))
        else $error("forward without preceding write");

endmodule

// ----- sim/tb_gaussian_blur_5x5.sv -----
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5;

    import gb5_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          RAND_ITEMS   = 700;
    localparam int unsigned KERN_SUM     = 273;

    localparam int unsigned WT [KSIZE][KSIZE] = '{
        '{1, 4,  7,  4,  1},
        '{4, 16, 26, 16, 4},
        '{7, 26, 41, 26, 7},
        '{4, 16, 26, 16, 4},
        '{1, 4,  7,  4,  1}
    };

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

    typedef struct packed {
        int               count;
        logic [PIX_W-1:0] px;
        logic             fs;
        logic             typed;
        int               want_f;
        int               want_x;
        int               want_y;
    } run_t;

    // all-255 frame at width 5: first full window is flat, so 255 at (2,2)
    run_t dir_runs [5] = '{
        '{1,  8'd255, 1'b1, 1'b0, 0,   0, 0},
        '{23, 8'd255, 1'b0, 1'b0, 0,   0, 0},
        '{1,  8'd255, 1'b0, 1'b1, 255, 2, 2},
        '{5,  8'd0,   1'b0, 1'b0, 0,   0, 0},
        '{2,  8'd0,   1'b1, 1'b0, 0,   0, 0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_stall;
    logic [PIX_W-1:0]     pixel;
    logic                 frame_start;
    logic                 res_valid;
    logic                 res_stall;
    logic [PIX_W-1:0]     filtered;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    logic [PIX_W-1:0]     row_mem [LINES][MAX_WIDTH];
    logic [PIX_W-1:0]     win_px [KSIZE][KSIZE];
    int unsigned          col_pos;
    int unsigned          row_pos;
    logic [CFG_W-1:0]     width_reg;
    gb5_res_t             blurred_q [$];

    int                   errors = 0;
    int unsigned          cycles = 0;
    int                   burst_left = 0;

    gaussian_blur_5x5 u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .filtered    (filtered),
        .center_x    (center_x),
        .center_y    (center_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void blur_pixel(input logic [PIX_W-1:0] px, input logic fs,
                                       output bit hit, output gb5_res_t res);
        int unsigned      w;
        int unsigned      x;
        int unsigned      sum;
        logic [PIX_W-1:0] colv [KSIZE];
        w = width_reg;
        if (w < KSIZE) w = KSIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        for (int r = 0; r < LINES; r++)
            colv[r] = row_mem[LINES-1-r][x];
        colv[KSIZE-1] = px;
        for (int r = LINES - 1; r > 0; r--)
            row_mem[r][x] = row_mem[r-1][x];
        row_mem[0][x] = px;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
                win_px[r][c] = win_px[r][c+1];
            win_px[r][KSIZE-1] = colv[r];
        end
        hit = (row_pos >= KSIZE - 1) && (col_pos >= KSIZE - 1);
        sum = 0;
        for (int r = 0; r < KSIZE; r++)
            for (int c = 0; c < KSIZE; c++)
                sum += WT[r][c] * win_px[r][c];
        res.filtered = PIX_W'(sum / KERN_SUM);
        res.cx       = COORD_W'(col_pos - 2);
        res.cy       = COORD_W'(row_pos - 2);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos < MAX_HEIGHT - 1) row_pos++;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        errors++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    task automatic send_beat(input logic [PIX_W-1:0] px, input logic fs,
                             input logic typed, input gb5_res_t want);
        bit       hit;
        gb5_res_t res;
        if (burst_left <= 0)
        begin
            pix_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
        end
        pix_valid   = 1'b1;
        pixel       = px;
        frame_start = fs;
        do @(posedge clk); while (pix_stall);
        blur_pixel(px, fs, hit, res);
        if (typed)
            blurred_q.push_back(want);
        else if (hit)
            blurred_q.push_back(res);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pix_valid = 1'b0;
        while (blurred_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        width_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        gb5_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (blurred_q.size() == 0)
            begin
                report_mismatch("unexpected beat, filtered", filtered, 0);
            end
            else
            begin
                want = blurred_q.pop_front();
                if (filtered !== want.filtered)
                    report_mismatch("filtered", filtered, want.filtered);
                if (center_x !== want.cx)
                    report_mismatch("center_x", center_x, want.cx);
                if (center_y !== want.cy)
                    report_mismatch("center_y", center_y, want.cy);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        stall_mode_t mode;
        int          len;
        res_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(20, 200);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  res_stall = 1'b0;
                    STALL_LIGHT: res_stall = ($urandom_range(0, 3) == 0);
                    STALL_HALF:  res_stall = ($urandom_range(0, 1) == 0);
                    default:     res_stall = ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int               n;
        int               sel;
        int               rand_items;
        bit               newf;
        logic             fs;
        logic [CFG_W-1:0] w;
        gb5_res_t         want;

        pix_valid   = 1'b0;
        pixel       = '0;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        for (int r = 0; r < LINES; r++)
            for (int x = 0; x < MAX_WIDTH; x++)
                row_mem[r][x] = '0;
        for (int r = 0; r < KSIZE; r++)
            for (int c = 0; c < KSIZE; c++)
                win_px[r][c] = '0;
        col_pos   = 0;
        row_pos   = 0;
        width_reg = CFG_W'(640);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        write_width(CFG_W'(KSIZE));
        for (int i = 0; i < 5; i++)
        begin
            for (int k = 0; k < dir_runs[i].count; k++)
            begin
                want.filtered = PIX_W'(dir_runs[i].want_f);
                want.cx       = COORD_W'(dir_runs[i].want_x);
                want.cy       = COORD_W'(dir_runs[i].want_y);
                send_beat(dir_runs[i].px, dir_runs[i].fs && (k == 0),
                          dir_runs[i].typed && (k == dir_runs[i].count - 1), want);
            end
        end

        // width changes land between rows and mid-row, frames start at random
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (rand_items == 0)
                w = '0;
            else if (sel == 0)
                w = CFG_W'($urandom_range(0, 4));
            else if (sel < 8)
                w = CFG_W'($urandom_range(5, 16));
            else if (sel < 9)
                w = CFG_W'($urandom_range(17, 80));
            else
                w = CFG_W'($urandom_range(MAX_WIDTH + 1, 2047));
            if (rand_items == 0 || $urandom_range(0, 2) == 0)
                write_width(w);
            newf = (rand_items == 0) || ($urandom_range(0, 1) == 0);
            n = $urandom_range(10, 120);
            for (int k = 0; k < n; k++)
            begin
                fs = (newf && k == 0) || ($urandom_range(0, 127) == 0);
                send_beat(PIX_W'($urandom_range(0, 255)), fs, 1'b0, '0);
                rand_items++;
            end
        end

        // four short rows, then the start of a full-width row, then an over-range width
        write_width(CFG_W'(KSIZE));
        for (int k = 0; k < 4 * KSIZE; k++)
            send_beat(PIX_W'($urandom_range(0, 255)), k == 0, 1'b0, '0);
        write_width(CFG_W'(MAX_WIDTH));
        for (int k = 0; k < 40; k++)
            send_beat(PIX_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        write_width('1);
        for (int k = 0; k < 30; k++)
            send_beat(PIX_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gb5_pkg.sv
hdl/gb5_ram.sv
hdl/gb5_kernel.sv
hdl/gaussian_blur_5x5.sv
sim/tb_gaussian_blur_5x5.sv
